// File: hdl/pvr_pkg.sv
// Shared types, widths and the arctangent table of the planar vector rotator.
// No dependencies; every rotator module imports this package.
`default_nettype none

package pvr_pkg;

  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int GUARD_BITS = 16;
  // Internal coordinate width: the gain-scaled input plus growth, with margin
  localparam int DATA_W     = 50;
  localparam int ANG_W      = 34;
  localparam int RND_W      = DATA_W - GUARD_BITS;
  localparam int MAX_STAGES = 32;

  localparam int ROTATION_STAGES_DEF = 24;
  localparam int COORD_BITS_DEF      = 32;

  // Gain compensation, unsigned Q0.32
  localparam logic [IN_W-1:0] GAIN_Q32 = 32'h9B74_EDA8;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } pvr_stage_t;

  // atan(2^-i) in binary angle units, 2^31 = pi
  function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sh0_2000_0000;
      5'd1:  v = 34'sh0_12E4_051E;
      5'd2:  v = 34'sh0_09FB_385B;
      5'd3:  v = 34'sh0_0511_11D4;
      5'd4:  v = 34'sh0_028B_0D43;
      5'd5:  v = 34'sh0_0145_D7E1;
      5'd6:  v = 34'sh0_00A2_F61E;
      5'd7:  v = 34'sh0_0051_7C55;
      5'd8:  v = 34'sh0_0028_BE53;
      5'd9:  v = 34'sh0_0014_5F2F;
      5'd10: v = 34'sh0_000A_2F98;
      5'd11: v = 34'sh0_0005_17CC;
      5'd12: v = 34'sh0_0002_8BE6;
      5'd13: v = 34'sh0_0001_45F3;
      5'd14: v = 34'sh0_0000_A2FA;
      5'd15: v = 34'sh0_0000_517D;
      5'd16: v = 34'sh0_0000_28BE;
      5'd17: v = 34'sh0_0000_145F;
      5'd18: v = 34'sh0_0000_0A30;
      5'd19: v = 34'sh0_0000_0518;
      5'd20: v = 34'sh0_0000_028C;
      5'd21: v = 34'sh0_0000_0146;
      5'd22: v = 34'sh0_0000_00A3;
      5'd23: v = 34'sh0_0000_0051;
      5'd24: v = 34'sh0_0000_0029;
      5'd25: v = 34'sh0_0000_0014;
      5'd26: v = 34'sh0_0000_000A;
      5'd27: v = 34'sh0_0000_0005;
      5'd28: v = 34'sh0_0000_0003;
      5'd29: v = 34'sh0_0000_0001;
      5'd30: v = 34'sh0_0000_0001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/pvr_front.sv
// Input stage of the rotator: gain multiply, angle setup and quarter-turn
// pre-rotation, two register stages. Depends on pvr_pkg.
`default_nettype none

module pvr_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [pvr_pkg::IN_W-1:0]      x_coord,
  input  wire logic [pvr_pkg::IN_W-1:0]      y_coord,
  input  wire logic [pvr_pkg::IN_W-1:0]      angle,
  input  wire logic                          mode,
  output pvr_pkg::pvr_stage_t                stage_out
);
  import pvr_pkg::*;

  logic signed [DATA_W+GUARD_BITS-1:0] prod_x;
  logic signed [DATA_W+GUARD_BITS-1:0] prod_y;
  logic signed [ANG_W-1:0]             angle_ext;
  logic signed [ANG_W-1:0]             z_in;

  logic                     s1_valid;
  logic signed [DATA_W-1:0] s1_x;
  logic signed [DATA_W-1:0] s1_y;
  logic signed [ANG_W-1:0]  s1_z;

  logic signed [DATA_W-1:0] pre_x_next;
  logic signed [DATA_W-1:0] pre_y_next;
  logic signed [ANG_W-1:0]  pre_z_next;

  logic                     pre_valid;
  logic signed [DATA_W-1:0] pre_x;
  logic signed [DATA_W-1:0] pre_y;
  logic signed [ANG_W-1:0]  pre_z;

  assign prod_x    = $signed(x_coord) * $signed({1'b0, GAIN_Q32});
  assign prod_y    = $signed(y_coord) * $signed({1'b0, GAIN_Q32});
  assign angle_ext = $signed({{(ANG_W-IN_W){angle[IN_W-1]}}, angle});
  // Clockwise turns by the negated angle
  assign z_in      = mode ? angle_ext : -angle_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_x <= prod_x[GUARD_BITS +: DATA_W];
    s1_y <= prod_y[GUARD_BITS +: DATA_W];
    s1_z <= z_in;
  end

  // Bring the angle into [-pi/2, pi/2] with an exact quarter turn
  always_comb begin
    pre_x_next = s1_x;
    pre_y_next = s1_y;
    pre_z_next = s1_z;
    if (s1_z > QUARTER_TURN) begin
      pre_x_next = -s1_y;
      pre_y_next = s1_x;
      pre_z_next = s1_z - QUARTER_TURN;
    end else if (s1_z < -QUARTER_TURN) begin
      pre_x_next = s1_y;
      pre_y_next = -s1_x;
      pre_z_next = s1_z + QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else begin
      pre_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    pre_x <= pre_x_next;
    pre_y <= pre_y_next;
    pre_z <= pre_z_next;
  end

  assign stage_out.valid = pre_valid;
  assign stage_out.x     = pre_x;
  assign stage_out.y     = pre_y;
  assign stage_out.z     = pre_z;

endmodule

`default_nettype wire

// File: hdl/pvr_cell.sv
// One micro-rotation cell of the rotator chain, one register stage.
// Depends on pvr_pkg for the stage type and the arctangent table.
`default_nettype none

module pvr_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pvr_pkg::pvr_stage_t stage_in,
  output pvr_pkg::pvr_stage_t     stage_out
);
  import pvr_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_val(5'(SHIFT));

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic signed [DATA_W-1:0] x_next;
  logic signed [DATA_W-1:0] y_next;
  logic signed [ANG_W-1:0]  z_next;

  logic                     valid;
  logic signed [DATA_W-1:0] x;
  logic signed [DATA_W-1:0] y;
  logic signed [ANG_W-1:0]  z;

  assign dx = stage_in.y >>> SHIFT;
  assign dy = stage_in.x >>> SHIFT;

  // Turn toward zero residual angle
  always_comb begin
    if (!stage_in.z[ANG_W-1]) begin
      x_next = stage_in.x - dx;
      y_next = stage_in.y + dy;
      z_next = stage_in.z - ATAN;
    end else begin
      x_next = stage_in.x + dx;
      y_next = stage_in.y - dy;
      z_next = stage_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
    z <= z_next;
  end

  assign stage_out.valid = valid;
  assign stage_out.x     = x;
  assign stage_out.y     = y;
  assign stage_out.z     = z;

endmodule

`default_nettype wire

// File: hdl/pvr_round.sv
// Output stage of the rotator: round off the guard bits, saturate, register.
// Depends on pvr_pkg.
`default_nettype none

module pvr_round #(
  parameter int COORD_BITS = pvr_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pvr_pkg::pvr_stage_t       stage_in,
  output logic                           done,
  output logic [pvr_pkg::OUT_W-1:0]      x_rot,
  output logic [pvr_pkg::OUT_W-1:0]      y_rot,
  output logic                           saturated
);
  import pvr_pkg::*;

  localparam int SAT_W = (COORD_BITS > OUT_W) ? OUT_W : ((COORD_BITS < 2) ? 2 : COORD_BITS);
  localparam logic signed [RND_W-1:0] SAT_HI =
    {{(RND_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [DATA_W-1:0] HALF = DATA_W'(1) << (GUARD_BITS-1);

  // Returns {clamp flag, clamped value}
  function automatic logic [RND_W:0] round_sat(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] sum;
    logic signed [RND_W-1:0]  r;
    logic [RND_W:0]           res;
    sum = v + HALF;
    r   = sum[DATA_W-1:GUARD_BITS];
    if (r > SAT_HI) begin
      res = {1'b1, SAT_HI};
    end else if (r < SAT_LO) begin
      res = {1'b1, SAT_LO};
    end else begin
      res = {1'b0, r};
    end
    return res;
  endfunction

  logic [RND_W:0] x_res;
  logic [RND_W:0] y_res;

  assign x_res = round_sat(stage_in.x);
  assign y_res = round_sat(stage_in.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    x_rot     <= x_res[OUT_W-1:0];
    y_rot     <= y_res[OUT_W-1:0];
    saturated <= x_res[RND_W] | y_res[RND_W];
  end

endmodule

`default_nettype wire

// File: hdl/planar_vector_rotator_top.sv
// Planar vector rotator: pipelined rotation of a Q16.16 point by a binary angle.
// Throughput: one transfer per cycle; busy is high only during reset; results never stall.
// Pipeline: an accepted item passes the gain multiply, the quarter-turn and one cell per stage
// (up to 32), then the rounding register, which raises done with the result.
// Reset (synchronous, active high) clears all valid bits; items in flight are dropped.
// Depends on pvr_pkg, pvr_front, pvr_cell and pvr_round.
`default_nettype none

module planar_vector_rotator_top #(
  parameter int ROTATION_STAGES = pvr_pkg::ROTATION_STAGES_DEF,
  parameter int COORD_BITS      = pvr_pkg::COORD_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [pvr_pkg::IN_W-1:0]  x_coord,
  input  wire logic [pvr_pkg::IN_W-1:0]  y_coord,
  input  wire logic [pvr_pkg::IN_W-1:0]  angle,
  input  wire logic                      mode,
  output logic                           done,
  output logic [pvr_pkg::OUT_W-1:0]      x_rot,
  output logic [pvr_pkg::OUT_W-1:0]      y_rot,
  output logic                           saturated
);
  import pvr_pkg::*;

  localparam int NCELL = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;

  pvr_stage_t chain [0:NCELL];

  assign busy = rst;

  pvr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (start & ~busy),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .angle     (angle),
    .mode      (mode),
    .stage_out (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pvr_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  pvr_round #(
    .COORD_BITS (COORD_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .stage_in  (chain[NCELL]),
    .done      (done),
    .x_rot     (x_rot),
    .y_rot     (y_rot),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

// File: hdl/pvr_checker.sv
// Port-level checks of the planar vector rotator, bound to the top level.
// Depends on pvr_pkg and planar_vector_rotator_top.
`default_nettype none

module pvr_checker #(
  parameter int ROTATION_STAGES = pvr_pkg::ROTATION_STAGES_DEF,
  parameter int COORD_BITS      = pvr_pkg::COORD_BITS_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic [pvr_pkg::OUT_W-1:0] x_rot,
  input wire logic [pvr_pkg::OUT_W-1:0] y_rot,
  input wire logic                     saturated
);
  import pvr_pkg::*;

  localparam int NCELL   = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;
  localparam int LATENCY = NCELL + 3;
  localparam int SAT_W   = (COORD_BITS > OUT_W) ? OUT_W : ((COORD_BITS < 2) ? 2 : COORD_BITS);
  localparam logic [OUT_W-1:0] SAT_HI = {{(OUT_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_LO = ~SAT_HI;

  // Never stall outside reset
  a_no_stall: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy high outside reset");

  // Each transfer produces exactly one strobe at the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result strobe without a transfer");

  // A clamped result sits on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (x_rot == SAT_HI || x_rot == SAT_LO || y_rot == SAT_HI || y_rot == SAT_LO))
    else $error("saturation flag without a clamped value");

endmodule

bind planar_vector_rotator_top pvr_checker #(
  .ROTATION_STAGES (ROTATION_STAGES),
  .COORD_BITS      (COORD_BITS)
) u_pvr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .x_rot     (x_rot),
  .y_rot     (y_rot),
  .saturated (saturated)
);

`default_nettype wire
